### design/rau_pkg.sv
// Shared constants and codes for the rational arithmetic unit.
package rau_pkg;

    localparam int RAU_WIDTH = 64;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

endpackage

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit: fraction normalize/add/sub/mul/div with GCD reduction.
//
// Usage:
//   Request channel: in_valid/in_stall with opcode, a_num, a_den, b_num, b_den.
//   A request is taken on a clock edge with in_valid high and in_stall low.
//   in_stall stays high from the accepting edge until the sequencer is idle
//   again, so one request is in flight at a time.
//   Result channel: out_valid/out_stall with res_num, res_den, status, held in
//   an output register. A result that waits under out_stall does not block
//   the next request from being taken; the sequencer waits only if it finishes
//   again before the old result is gone.
//   One sequencer shares a binary GCD unit (one step per cycle), a restoring
//   divider (one quotient bit per cycle, short or long) and a shift-add
//   multiplier. Normalize needs one GCD and two short divides; add/subtract
//   need four GCDs, nine divides (two of them long) and three multiplies.
//   Reset: rst_n is asynchronous; the sequencer returns to idle and any
//   pending result is dropped.
//   Errors give res_num 0, res_den 1 with status zero-denominator or overflow.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic signed [63:0]  a_num,
    input  logic signed [63:0]  a_den,
    input  logic signed [63:0]  b_num,
    input  logic signed [63:0]  b_den,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  res_num,
    output logic [62:0]         res_den,
    output logic [1:0]          status
);

    localparam int W2 = 2 * WIDTH;
    localparam int CW = $clog2(W2 + 1);
    localparam int KW = $clog2(WIDTH);

    // Sequencer states, one-hot.
    typedef enum logic [31:0] {
        S_IDLE  = 32'h0000_0001,
        S_LDA   = 32'h0000_0002,
        S_A_DN  = 32'h0000_0004,
        S_A_DD  = 32'h0000_0008,
        S_A_END = 32'h0000_0010,
        S_LDB   = 32'h0000_0020,
        S_B_DN  = 32'h0000_0040,
        S_B_DD  = 32'h0000_0080,
        S_B_END = 32'h0000_0100,
        S_M_G1  = 32'h0000_0200,
        S_M_G2  = 32'h0000_0400,
        S_M_D1  = 32'h0000_0800,
        S_M_D2  = 32'h0000_1000,
        S_M_D3  = 32'h0000_2000,
        S_M_D4  = 32'h0000_4000,
        S_M_P1  = 32'h0000_8000,
        S_M_P2  = 32'h0001_0000,
        S_D_G   = 32'h0002_0000,
        S_D_Q1  = 32'h0004_0000,
        S_D_Q2  = 32'h0008_0000,
        S_D_X   = 32'h0010_0000,
        S_D_Y   = 32'h0020_0000,
        S_D_T   = 32'h0040_0000,
        S_D_R   = 32'h0080_0000,
        S_D_Q3  = 32'h0100_0000,
        S_D_Q4  = 32'h0200_0000,
        S_D_Q5  = 32'h0400_0000,
        S_X_END = 32'h0800_0000,
        S_FIN   = 32'h1000_0000,
        S_U_GCD = 32'h2000_0000,
        S_U_GFX = 32'h4000_0000,
        S_U_DIV = 32'h8000_0000
    } state_t;

    typedef enum logic [1:0] {
        U_NONE = 2'd0,
        U_GCD  = 2'd1,
        U_DIV  = 2'd2,
        U_MUL  = 2'd3
    } unit_t;

    // Multiply runs under its own flag; the sequencer waits in its return state.
    state_t state_reg, state_next, ret_reg, ret_next;
    op_t    op_reg, op_next;
    logic   mul_busy_reg, mul_busy_next;

    logic [WIDTH-1:0] na_reg, na_next, da_reg, da_next, nb_reg, nb_next, db_reg, db_next;
    logic             sa_reg, sa_next, sb_reg, sb_next, s_reg, s_next;
    logic [WIDTH-1:0] g_reg, g_next, h_reg, h_next, e_reg, e_next;
    logic [W2-1:0]    x_reg, x_next, rn_reg, rn_next, rd_reg, rd_next;
    status_t          st_reg, st_next;

    // Shared units.
    logic [WIDTH-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [KW-1:0]    gk_reg, gk_next;
    logic [W2-1:0]    dq_reg, dq_next;
    logic [WIDTH-1:0] dr_reg, dr_next, dd_reg, dd_next, ma_reg, ma_next;
    logic [W2-1:0]    prod_reg, prod_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] res_num_reg, res_num_next;
    logic [62:0]        res_den_reg, res_den_next;
    logic [1:0]         status_reg, status_next;

    // Request to a shared unit.
    unit_t            req_unit;
    logic [W2-1:0]    req_a;
    logic [WIDTH-1:0] req_b;
    logic             req_long;
    state_t           req_ret;

    // Input decode.
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd, mag_an, mag_ad, mag_bn, mag_bd;
    op_t              in_op;

    // Datapath temps.
    logic [WIDTH:0]   div_rem;
    logic             div_ge;
    logic [WIDTH:0]   mul_sum;
    logic [W2-1:0]    t_val;
    logic             t_sgn;
    status_t          fin_st;
    logic [WIDTH-1:0] fin_num;
    logic signed [WIDTH-1:0] fin_num_s;
    logic [WIDTH-2:0] fin_den;

    assign in_an  = a_num[WIDTH-1:0];
    assign in_ad  = a_den[WIDTH-1:0];
    assign in_bn  = b_num[WIDTH-1:0];
    assign in_bd  = b_den[WIDTH-1:0];
    assign mag_an = in_an[WIDTH-1] ? -in_an : in_an;
    assign mag_ad = in_ad[WIDTH-1] ? -in_ad : in_ad;
    assign mag_bn = in_bn[WIDTH-1] ? -in_bn : in_bn;
    assign mag_bd = in_bd[WIDTH-1] ? -in_bd : in_bd;

    always_comb
    begin
        case (opcode)
            OP_ADD:  in_op = OP_ADD;
            OP_SUB:  in_op = OP_SUB;
            OP_MUL:  in_op = OP_MUL;
            OP_DIV:  in_op = OP_DIV;
            default: in_op = OP_NORM;   // unused codes act as normalize
        endcase
    end

    assign div_rem = {dr_reg, dq_reg[W2-1]};
    assign div_ge  = (div_rem >= {1'b0, dd_reg});
    assign mul_sum = {1'b0, prod_reg[W2-1:WIDTH]} + (prod_reg[0] ? {1'b0, ma_reg} : '0);

    // Combine the two cross products with signs.
    always_comb
    begin
        if (sa_reg == sb_reg)
        begin
            t_val = x_reg + prod_reg;
            t_sgn = sa_reg;
        end
        else if (x_reg < prod_reg)
        begin
            t_val = prod_reg - x_reg;
            t_sgn = sb_reg;
        end
        else
        begin
            t_val = x_reg - prod_reg;
            t_sgn = sa_reg;
        end
    end

    // Final range check and formatting.
    always_comb
    begin
        fin_st = st_reg;
        if (st_reg == ST_OK &&
            (rn_reg[W2-1:WIDTH-1] != '0 || rd_reg[W2-1:WIDTH-1] != '0))
            fin_st = ST_OVF;
        if (fin_st != ST_OK || rn_reg == '0)
        begin
            fin_num = '0;
            fin_den = {{(WIDTH-2){1'b0}}, 1'b1};
        end
        else
        begin
            fin_num = s_reg ? -rn_reg[WIDTH-1:0] : rn_reg[WIDTH-1:0];
            fin_den = rd_reg[WIDTH-2:0];
        end
        fin_num_s = fin_num;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        op_next       = op_reg;
        mul_busy_next = mul_busy_reg;
        na_next = na_reg;  da_next = da_reg;  nb_next = nb_reg;  db_next = db_reg;
        sa_next = sa_reg;  sb_next = sb_reg;  s_next = s_reg;
        g_next  = g_reg;   h_next  = h_reg;   e_next = e_reg;
        x_next  = x_reg;   rn_next = rn_reg;  rd_next = rd_reg;  st_next = st_reg;
        ga_next = ga_reg;  gb_next = gb_reg;  gk_next = gk_reg;
        dq_next = dq_reg;  dr_next = dr_reg;  dd_next = dd_reg;
        ma_next = ma_reg;  prod_next = prod_reg;  cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        status_next    = status_reg;

        req_unit = U_NONE;
        req_a    = '0;
        req_b    = '0;
        req_long = 1'b0;
        req_ret  = S_IDLE;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_op;
                    na_next = mag_an;
                    da_next = mag_ad;
                    nb_next = mag_bn;
                    db_next = mag_bd;
                    sa_next = (mag_an != '0) && (in_an[WIDTH-1] != in_ad[WIDTH-1]);
                    sb_next = (mag_bn != '0) && (in_bn[WIDTH-1] != in_bd[WIDTH-1]);
                    state_next = S_LDA;
                end
            end
            // Operand A to lowest terms.
            S_LDA:
            begin
                if (da_reg == '0)
                begin
                    st_next = ST_ZDEN;
                    rn_next = '0;
                    rd_next = W2'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    req_unit = U_GCD; req_a = W2'(na_reg); req_b = da_reg; req_ret = S_A_DN;
                end
            end
            S_A_DN:
            begin
                g_next = ga_reg;
                req_unit = U_DIV; req_a = W2'(na_reg); req_b = ga_reg; req_ret = S_A_DD;
            end
            S_A_DD:
            begin
                na_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(da_reg); req_b = g_reg; req_ret = S_A_END;
            end
            S_A_END:
            begin
                da_next = dq_reg[WIDTH-1:0];
                if (op_reg == OP_NORM)
                begin
                    st_next = ST_OK;
                    s_next  = sa_reg;
                    rn_next = W2'(na_reg);
                    rd_next = W2'(dq_reg[WIDTH-1:0]);
                    state_next = S_FIN;
                end
                else
                    state_next = S_LDB;
            end
            // Operand B to lowest terms.
            S_LDB:
            begin
                if (db_reg == '0)
                begin
                    st_next = ST_ZDEN;
                    rn_next = '0;
                    rd_next = W2'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    req_unit = U_GCD; req_a = W2'(nb_reg); req_b = db_reg; req_ret = S_B_DN;
                end
            end
            S_B_DN:
            begin
                g_next = ga_reg;
                req_unit = U_DIV; req_a = W2'(nb_reg); req_b = ga_reg; req_ret = S_B_DD;
            end
            S_B_DD:
            begin
                nb_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(db_reg); req_b = g_reg; req_ret = S_B_END;
            end
            S_B_END:
            begin
                st_next = ST_OK;
                if (op_reg == OP_DIV && nb_reg == '0)
                begin
                    st_next = ST_ZDEN;
                    rn_next = '0;
                    rd_next = W2'(1);
                    state_next = S_FIN;
                end
                else if (op_reg == OP_DIV)
                begin
                    // divide is multiply by the reciprocal
                    nb_next = dq_reg[WIDTH-1:0];
                    db_next = nb_reg;
                    s_next  = sa_reg ^ sb_reg;
                    state_next = S_M_G1;
                end
                else if (op_reg == OP_MUL)
                begin
                    db_next = dq_reg[WIDTH-1:0];
                    s_next  = sa_reg ^ sb_reg;
                    state_next = S_M_G1;
                end
                else
                begin
                    db_next = dq_reg[WIDTH-1:0];
                    if (op_reg == OP_SUB)
                        sb_next = (nb_reg != '0) && !sb_reg;
                    state_next = S_D_G;
                end
            end
            // Multiply with cross reduction.
            S_M_G1:
            begin
                if (na_reg == '0 || nb_reg == '0)
                begin
                    rn_next = '0;
                    rd_next = W2'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    req_unit = U_GCD; req_a = W2'(na_reg); req_b = db_reg; req_ret = S_M_G2;
                end
            end
            S_M_G2:
            begin
                g_next = ga_reg;
                req_unit = U_GCD; req_a = W2'(nb_reg); req_b = da_reg; req_ret = S_M_D1;
            end
            S_M_D1:
            begin
                h_next = ga_reg;
                req_unit = U_DIV; req_a = W2'(na_reg); req_b = g_reg; req_ret = S_M_D2;
            end
            S_M_D2:
            begin
                na_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(nb_reg); req_b = h_reg; req_ret = S_M_D3;
            end
            S_M_D3:
            begin
                nb_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(da_reg); req_b = h_reg; req_ret = S_M_D4;
            end
            S_M_D4:
            begin
                da_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(db_reg); req_b = g_reg; req_ret = S_M_P1;
            end
            S_M_P1:
            begin
                db_next = dq_reg[WIDTH-1:0];
                req_unit = U_MUL; req_a = W2'(na_reg); req_b = nb_reg; req_ret = S_M_P2;
            end
            S_M_P2:
            begin
                if (!mul_busy_reg)
                begin
                    rn_next = prod_reg;
                    req_unit = U_MUL; req_a = W2'(da_reg); req_b = db_reg;
                    req_ret = S_X_END;
                end
            end
            // Add/subtract over the denominators' gcd.
            S_D_G:
            begin
                req_unit = U_GCD; req_a = W2'(da_reg); req_b = db_reg; req_ret = S_D_Q1;
            end
            S_D_Q1:
            begin
                g_next = ga_reg;
                req_unit = U_DIV; req_a = W2'(db_reg); req_b = ga_reg; req_ret = S_D_Q2;
            end
            S_D_Q2:
            begin
                e_next = dq_reg[WIDTH-1:0];
                req_unit = U_DIV; req_a = W2'(da_reg); req_b = g_reg; req_ret = S_D_X;
            end
            S_D_X:
            begin
                da_next = dq_reg[WIDTH-1:0];
                req_unit = U_MUL; req_a = W2'(na_reg); req_b = e_reg; req_ret = S_D_Y;
            end
            S_D_Y:
            begin
                if (!mul_busy_reg)
                begin
                    x_next = prod_reg;
                    req_unit = U_MUL; req_a = W2'(nb_reg); req_b = da_reg; req_ret = S_D_T;
                end
            end
            S_D_T:
            begin
                if (!mul_busy_reg)
                begin
                    if (t_val == '0)
                    begin
                        rn_next = '0;
                        rd_next = W2'(1);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x_next = t_val;
                        s_next = t_sgn;
                        req_unit = U_DIV; req_a = t_val; req_b = g_reg; req_long = 1'b1;
                        req_ret = S_D_R;
                    end
                end
            end
            S_D_R:
            begin
                req_unit = U_GCD; req_a = W2'(dr_reg); req_b = g_reg; req_ret = S_D_Q3;
            end
            S_D_Q3:
            begin
                h_next = ga_reg;
                req_unit = U_DIV; req_a = x_reg; req_b = ga_reg; req_long = 1'b1;
                req_ret = S_D_Q4;
            end
            S_D_Q4:
            begin
                rn_next = dq_reg;
                req_unit = U_DIV; req_a = W2'(db_reg); req_b = h_reg; req_ret = S_D_Q5;
            end
            S_D_Q5:
            begin
                req_unit = U_MUL; req_a = W2'(da_reg); req_b = dq_reg[WIDTH-1:0];
                req_ret = S_X_END;
            end
            S_X_END:
            begin
                if (!mul_busy_reg)
                begin
                    rd_next = prod_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    res_num_next   = 64'(fin_num_s);
                    res_den_next   = 63'(fin_den);
                    status_next    = fin_st;
                    state_next     = S_IDLE;
                end
            end
            // Binary gcd, one step per cycle; the common power of two is
            // restored afterwards in S_U_GFX.
            S_U_GCD:
            begin
                if (gb_reg == '0)
                    state_next = S_U_GFX;
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + KW'(1);
                end
                else if (!ga_reg[0])
                    ga_next = ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_next = gb_reg >> 1;
                else if (ga_reg > gb_reg)
                begin
                    ga_next = gb_reg;
                    gb_next = ga_reg - gb_reg;
                end
                else
                    gb_next = gb_reg - ga_reg;
            end
            S_U_GFX:
            begin
                if (gk_reg == '0)
                    state_next = ret_reg;
                else
                begin
                    ga_next = ga_reg << 1;
                    gk_next = gk_reg - KW'(1);
                end
            end
            // Restoring divide, one quotient bit per cycle.
            S_U_DIV:
            begin
                dr_next = div_ge ? WIDTH'(div_rem - {1'b0, dd_reg}) : div_rem[WIDTH-1:0];
                dq_next = {dq_reg[W2-2:0], div_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = ret_reg;
            end
            default:
                state_next = S_IDLE;
        endcase

        // Shift-add multiply runs beside the sequencer.
        if (mul_busy_reg)
        begin
            prod_next = {mul_sum, prod_reg[WIDTH-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                mul_busy_next = 1'b0;
        end

        // Launch a shared unit.
        case (req_unit)
            U_GCD:
            begin
                ga_next = (req_a[WIDTH-1:0] == '0) ? req_b : req_a[WIDTH-1:0];
                gb_next = (req_a[WIDTH-1:0] == '0) ? '0 : req_b;
                gk_next = '0;
                ret_next = req_ret;
                state_next = S_U_GCD;
            end
            U_DIV:
            begin
                dq_next  = req_long ? req_a : {req_a[WIDTH-1:0], {WIDTH{1'b0}}};
                dr_next  = '0;
                dd_next  = req_b;
                cnt_next = req_long ? CW'(W2) : CW'(WIDTH);
                ret_next = req_ret;
                state_next = S_U_DIV;
            end
            U_MUL:
            begin
                ma_next   = req_a[WIDTH-1:0];
                prod_next = {{WIDTH{1'b0}}, req_b};
                cnt_next  = CW'(WIDTH);
                mul_busy_next = 1'b1;
                state_next = req_ret;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            mul_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            mul_busy_reg  <= mul_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        na_reg <= na_next;  da_reg <= da_next;  nb_reg <= nb_next;  db_reg <= db_next;
        sa_reg <= sa_next;  sb_reg <= sb_next;  s_reg  <= s_next;
        g_reg  <= g_next;   h_reg  <= h_next;   e_reg  <= e_next;
        x_reg  <= x_next;   rn_reg <= rn_next;  rd_reg <= rd_next;  st_reg <= st_next;
        ga_reg <= ga_next;  gb_reg <= gb_next;  gk_reg <= gk_next;
        dq_reg <= dq_next;  dr_reg <= dr_next;  dd_reg <= dd_next;
        ma_reg <= ma_next;  prod_reg <= prod_next;  cnt_reg <= cnt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        status_reg  <= status_next;
    end

endmodule
